>>> hw/rtl/vector_field_splat_accumulate_unit_defines.svh
// assertion macros for the splat accumulate unit
`ifndef VECTOR_FIELD_SPLAT_ACCUMULATE_UNIT_DEFINES_SVH
`define VECTOR_FIELD_SPLAT_ACCUMULATE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define VFSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vfsa check failed");
`define VFSA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vfsa check failed");
`else
`define VFSA_ASSERT_IMP(label, ante, cons)
`define VFSA_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/vfsa_pkg.sv
`default_nettype none

package vfsa_pkg;

  localparam int MAX_EDGE   = 64;
  localparam int MAX_VOXELS = 262144;

  localparam int IDX_W   = 18;
  localparam int VAL_W   = 32;
  localparam int CMD_W   = 2;
  localparam int DIR_W   = 16;
  localparam int STAT_W  = 2;
  localparam int SIZE_W  = 7;
  localparam int STEP_W  = 16;
  localparam int WGT_W   = 24;
  localparam int CFG_W   = 24;
  localparam int CIDX_W  = 3;

  localparam int EDGE_W  = $clog2(MAX_EDGE + 1);
  localparam int COORD_W = $clog2(MAX_EDGE);
  localparam int PLANE_W = 2 * COORD_W + 1;
  localparam int TOTAL_W = 3 * COORD_W + 1;
  localparam int ADDR_W  = $clog2(MAX_VOXELS);

  localparam logic [CMD_W-1:0] CMD_SPLAT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RDCLR = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_OUT = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT = 2'd2;

  localparam logic [CIDX_W-1:0] REG_SIZE_X = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SIZE_Y = 3'd1;
  localparam logic [CIDX_W-1:0] REG_SIZE_Z = 3'd2;
  localparam logic [CIDX_W-1:0] REG_STEP   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_WEIGHT = 3'd4;

  localparam logic [SIZE_W-1:0] RST_SIZE   = 7'd64;
  localparam logic [STEP_W-1:0] RST_STEP   = 16'd384;
  localparam logic [WGT_W-1:0]  RST_WEIGHT = 24'd2621;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        voxel_index;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } vfsa_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  target_index;
    logic [VAL_W-1:0]  value;
    logic [STAT_W-1:0] status;
  } vfsa_out_t;

  function automatic logic [EDGE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [EDGE_W-1:0] r;
    if (s == '0) begin
      r = EDGE_W'(1);
    end else if (int'(s) > MAX_EDGE) begin
      r = EDGE_W'(MAX_EDGE);
    end else begin
      r = EDGE_W'(s);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/vector_field_splat_accumulate_unit.sv
// a splat runs sizes, check, divide, coordinates, address, read, update; a read goes
// to read; the next word can be taken in the cycle after the result is registered
// splat time is set by a 12-step shared compare-subtract divider and one shared 17x17
// multiplier reused for sizes, displacement and address under one sequencer
// rst_n is synchronous active low: registers go to defaults, then a clearing pass writes
// zero to all 262144 store entries, one per cycle, while in_stall stays high
`default_nettype none
`include "vector_field_splat_accumulate_unit_defines.svh"

module vector_field_splat_accumulate_unit
  import vfsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire vfsa_in_t          in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output vfsa_out_t              out_word,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  localparam int ST_W   = 4;
  localparam int CNT_W  = $clog2(COORD_W);
  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;
  localparam int FRAC_W = 22;
  localparam int POS_W  = 36;
  localparam int RQ_W   = POS_W - FRAC_W;
  localparam int DIV_W  = IDX_W + 2;
  localparam int SUM_W  = VAL_W + 1;

  localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] S_CLEAR = 4'd1;
  localparam logic [ST_W-1:0] S_PLANE = 4'd2;
  localparam logic [ST_W-1:0] S_TOTAL = 4'd3;
  localparam logic [ST_W-1:0] S_CHECK = 4'd4;
  localparam logic [ST_W-1:0] S_DIVZ  = 4'd5;
  localparam logic [ST_W-1:0] S_DIVY  = 4'd6;
  localparam logic [ST_W-1:0] S_CMUL  = 4'd7;
  localparam logic [ST_W-1:0] S_CRND  = 4'd8;
  localparam logic [ST_W-1:0] S_ADR1  = 4'd9;
  localparam logic [ST_W-1:0] S_ADR2  = 4'd10;
  localparam logic [ST_W-1:0] S_ADR3  = 4'd11;
  localparam logic [ST_W-1:0] S_RD    = 4'd12;
  localparam logic [ST_W-1:0] S_UPD   = 4'd13;
  localparam logic [ST_W-1:0] S_FIN   = 4'd14;

  localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(MAX_VOXELS - 1);
  localparam logic [CNT_W-1:0]  CNT_FIRST = CNT_W'(COORD_W - 1);
  localparam logic signed [POS_W-1:0] RND_HALF = POS_W'(1) << (FRAC_W - 1);

  logic [ST_W-1:0]    state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic               out_valid_r;
  vfsa_out_t          out_word_r;
  vfsa_out_t          res_r;
  vfsa_in_t           in_r;

  logic [SIZE_W-1:0]  size_x_r, size_y_r, size_z_r;
  logic [STEP_W-1:0]  step_r;
  logic [WGT_W-1:0]   weight_r;
  logic [EDGE_W-1:0]  sx_eff, sy_eff, sz_eff;

  logic [PLANE_W-1:0] plane_r;
  logic [TOTAL_W-1:0] total_r;
  logic [IDX_W-1:0]   rem_r;
  logic [COORD_W-1:0] q_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [1:0]         csel_r;
  logic [COORD_W-1:0] coord_r [3];
  logic signed [PROD_W-1:0] prod_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [VAL_W-1:0]   rd_data_r;
  logic [VAL_W-1:0]   mem [MAX_VOXELS];

  logic               in_acc, out_free, out_of_vol;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [DIV_W-1:0]   div_d, div_sh;
  logic               div_ge;
  logic [IDX_W-1:0]   rem_nxt;
  logic [COORD_W-1:0] q_nxt;
  logic signed [DIR_W-1:0] dir_sel;
  logic [EDGE_W-1:0]  size_sel, lim;
  logic signed [POS_W-1:0] pos_s, rnd_s;
  logic [RQ_W-1:0]    rq;
  logic [COORD_W-1:0] rnd_c;
  logic [SUM_W-1:0]   sum;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [VAL_W-1:0]   mem_wdata;

  assign sx_eff    = eff_size(size_x_r);
  assign sy_eff    = eff_size(size_y_r);
  assign sz_eff    = eff_size(size_z_r);
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_of_vol = TOTAL_W'(in_r.voxel_index) >= total_r;

  // shared multiplier
  always_comb begin
    case (csel_r)
      2'd0:    dir_sel = in_r.dir_x;
      2'd1:    dir_sel = in_r.dir_y;
      default: dir_sel = in_r.dir_z;
    endcase
    case (state_r)
      S_PLANE: begin
        mul_a = MUL_W'(sx_eff);
        mul_b = MUL_W'(sy_eff);
      end
      S_TOTAL: begin
        mul_a = MUL_W'(plane_r);
        mul_b = MUL_W'(sz_eff);
      end
      S_CMUL: begin
        mul_a = MUL_W'(dir_sel);
        mul_b = MUL_W'(step_r);
      end
      S_ADR1: begin
        mul_a = MUL_W'(coord_r[1]);
        mul_b = MUL_W'(sx_eff);
      end
      S_ADR2: begin
        mul_a = MUL_W'(coord_r[2]);
        mul_b = MUL_W'(plane_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // shared compare-subtract step of the divider
  assign div_d   = (state_r == S_DIVZ) ? DIV_W'(plane_r) : DIV_W'(sx_eff);
  assign div_sh  = div_d << cnt_r;
  assign div_ge  = DIV_W'(rem_r) >= div_sh;
  assign rem_nxt = div_ge ? IDX_W'(DIV_W'(rem_r) - div_sh) : rem_r;
  assign q_nxt   = {q_r[COORD_W-2:0], div_ge};

  // move, round and clamp one coordinate
  always_comb begin
    case (csel_r)
      2'd0:    size_sel = sx_eff;
      2'd1:    size_sel = sy_eff;
      default: size_sel = sz_eff;
    endcase
    lim   = size_sel - EDGE_W'(1);
    pos_s = $signed({{(POS_W - COORD_W - FRAC_W){1'b0}}, coord_r[csel_r], {FRAC_W{1'b0}}})
            + POS_W'(prod_r);
    rnd_s = pos_s + RND_HALF;
    rq    = rnd_s[POS_W-1:FRAC_W];
    if (pos_s[POS_W-1]) begin
      rnd_c = '0;
    end else if (rq > RQ_W'(lim)) begin
      rnd_c = lim[COORD_W-1:0];
    end else begin
      rnd_c = rq[COORD_W-1:0];
    end
  end

  assign sum = SUM_W'(rd_data_r) + SUM_W'(weight_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '0;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
    end else if (state_r == S_UPD) begin
      if (in_r.cmd == CMD_SPLAT) begin
        mem_we    = 1'b1;
        mem_wdata = sum[SUM_W-1] ? '1 : sum[VAL_W-1:0];
      end else if (in_r.cmd == CMD_RDCLR) begin
        mem_we    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[addr_r];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == CLR_LAST) state_nxt = S_IDLE;
      S_IDLE:  if (in_acc) state_nxt = S_PLANE;
      S_PLANE: state_nxt = S_TOTAL;
      S_TOTAL: state_nxt = S_CHECK;
      S_CHECK: begin
        if (out_of_vol) begin
          state_nxt = S_FIN;
        end else if (in_r.cmd == CMD_SPLAT) begin
          state_nxt = S_DIVZ;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_DIVZ:  if (cnt_r == '0) state_nxt = S_DIVY;
      S_DIVY:  if (cnt_r == '0) state_nxt = S_CMUL;
      S_CMUL:  state_nxt = S_CRND;
      S_CRND:  state_nxt = (csel_r == 2'd2) ? S_ADR1 : S_CMUL;
      S_ADR1:  state_nxt = S_ADR2;
      S_ADR2:  state_nxt = S_ADR3;
      S_ADR3:  state_nxt = S_RD;
      S_RD:    state_nxt = S_UPD;
      S_UPD:   state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      size_x_r    <= RST_SIZE;
      size_y_r    <= RST_SIZE;
      size_z_r    <= RST_SIZE;
      step_r      <= RST_STEP;
      weight_r    <= RST_WEIGHT;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SIZE_X: size_x_r <= cfg_wdata[SIZE_W-1:0];
          REG_SIZE_Y: size_y_r <= cfg_wdata[SIZE_W-1:0];
          REG_SIZE_Z: size_z_r <= cfg_wdata[SIZE_W-1:0];
          REG_STEP:   step_r   <= cfg_wdata[STEP_W-1:0];
          REG_WEIGHT: weight_r <= cfg_wdata[WGT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_word;
    end
    case (state_r)
      S_PLANE: plane_r <= mul_p[PLANE_W-1:0];
      S_TOTAL: total_r <= mul_p[TOTAL_W-1:0];
      S_CHECK: begin
        addr_r <= in_r.voxel_index;
        rem_r  <= in_r.voxel_index;
        cnt_r  <= CNT_FIRST;
        q_r    <= '0;
        res_r.target_index <= in_r.voxel_index;
        res_r.value        <= '0;
        res_r.status       <= ST_OUT;
      end
      S_DIVZ: begin
        rem_r <= rem_nxt;
        if (cnt_r == '0) begin
          coord_r[2] <= q_nxt;
          q_r        <= '0;
          cnt_r      <= CNT_FIRST;
        end else begin
          q_r   <= q_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
      S_DIVY: begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          coord_r[1] <= q_nxt;
          coord_r[0] <= rem_nxt[COORD_W-1:0];
          csel_r     <= 2'd0;
        end
      end
      S_CMUL: prod_r <= mul_p;
      S_CRND: begin
        coord_r[csel_r] <= rnd_c;
        csel_r          <= csel_r + 2'd1;
      end
      S_ADR1: prod_r <= mul_p;
      S_ADR2: begin
        addr_r <= ADDR_W'(coord_r[0]) + prod_r[ADDR_W-1:0];
        prod_r <= mul_p;
      end
      S_ADR3: addr_r <= addr_r + prod_r[ADDR_W-1:0];
      S_UPD: begin
        res_r.target_index <= addr_r;
        if (in_r.cmd == CMD_SPLAT) begin
          if (sum[SUM_W-1]) begin
            res_r.value  <= '1;
            res_r.status <= ST_SAT;
          end else begin
            res_r.value  <= sum[VAL_W-1:0];
            res_r.status <= ST_OK;
          end
        end else begin
          res_r.value  <= rd_data_r;
          res_r.status <= ST_OK;
        end
      end
      S_FIN: if (out_free) out_word_r <= res_r;
      default: ;
    endcase
  end

  `VFSA_ASSERT_IMP(a_accept_idle, in_valid && !in_stall, state_r == S_IDLE)
  `VFSA_ASSERT_IMP(a_sat_all_ones, out_valid_r && out_word_r.status == ST_SAT, out_word_r.value == '1)
  `VFSA_ASSERT_IMP(a_outside_zero, out_valid_r && out_word_r.status == ST_OUT, out_word_r.value == '0)
  `VFSA_ASSERT_NXT(a_read_then_update, state_r == S_RD, state_r == S_UPD)
  `VFSA_ASSERT_IMP(a_x_in_range, state_r == S_CMUL && csel_r == 2'd0, EDGE_W'(coord_r[0]) < sx_eff)

endmodule

`default_nettype wire
